// ----- hdl/per_vertex_color_averager_core_assert.svh -----
// Assertion macros shared by the per-vertex color averager modules.
`ifndef PER_VERTEX_COLOR_AVERAGER_CORE_ASSERT_SVH
`define PER_VERTEX_COLOR_AVERAGER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PVCA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PVCA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/pvca_pkg.sv -----
// Package: request/result types, opcodes and controller interface types.
`timescale 1ns / 1ps
package pvca_pkg;

  localparam logic [1:0] OP_ACC      = 2'd0;
  localparam logic [1:0] OP_READ     = 2'd1;
  localparam logic [1:0] OP_READ_CLR = 2'd2;
  localparam logic [1:0] OP_NOP      = 2'd3;

  localparam int MEAN_BITS   = 8;
  localparam int QUOT_STEPS  = 8;
  localparam int STEP_BITS   = 3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] vertex_index;
    logic [7:0]  red_sample;
    logic [7:0]  green_sample;
    logic [7:0]  blue_sample;
  } request_t;

  typedef struct packed {
    logic [11:0] slot_index;
    logic [7:0]  mean_red;
    logic [7:0]  mean_green;
    logic [7:0]  mean_blue;
    logic [15:0] sample_count;
    logic        no_samples;
  } result_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic div_step;
    logic clear_step;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic div_last;
    logic clear_last;
  } status_t;

endpackage

// ----- hdl/pvca_ctrl.sv -----
// Controller: sequences slot clearing, fetch, update and division steps.
`timescale 1ns / 1ps
`include "per_vertex_color_averager_core_assert.svh"
module pvca_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pvca_pkg::status_t status,
  output pvca_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (status.clear_last) state_next = S_IDLE;
      S_IDLE:  if (start) state_next = S_FETCH;
      S_FETCH: state_next = S_EXEC;
      S_EXEC:  state_next = status.is_read ? S_DIV : S_IDLE;
      S_DIV:   if (status.div_last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy           = (state != S_IDLE);
  assign cmd.load       = start && (state == S_IDLE);
  assign cmd.exec       = (state == S_EXEC);
  assign cmd.div_step   = (state == S_DIV);
  assign cmd.clear_step = (state == S_CLEAR);

  `PVCA_ASSERT_SAME(a_no_load_in_clear, clk, rst, state == S_CLEAR, !cmd.load, "request taken during clear")
  `PVCA_ASSERT_NEXT(a_div_ends_idle, clk, rst, cmd.div_step && status.div_last, state == S_IDLE, "division did not end")

endmodule

// ----- hdl/pvca_datapath.sv -----
// Datapath: slot memory, accumulate/clear update and three-lane radix-2 divider.
`timescale 1ns / 1ps
`include "per_vertex_color_averager_core_assert.svh"
module pvca_datapath #(
  parameter int SLOT_DEPTH = 4096,
  parameter int COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  pvca_pkg::request_t request,
  input  pvca_pkg::cmd_t     cmd,
  output pvca_pkg::status_t  status,
  output pvca_pkg::result_t  result,
  output logic               done
);

  localparam int AW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int SW = pvca_pkg::MEAN_BITS + COUNT_BITS;
  localparam int WW = 3 * SW + COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;
  localparam logic [AW-1:0] LastAddr = AW'(SLOT_DEPTH - 1);

  logic [WW-1:0] mem [SLOT_DEPTH];
  logic [WW-1:0] rd_q;
  logic [WW-1:0] word;
  logic [WW-1:0] mem_wdata;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] clr_addr;
  logic          mem_we;

  pvca_pkg::request_t req_q;
  logic               slot_ok;

  logic [COUNT_BITS-1:0] cnt;
  logic [7:0]            samp [3];

  logic [SW-1:0]                     rem [3];
  logic [SW-1:0]                     rem_next [3];
  logic [pvca_pkg::MEAN_BITS-1:0]    quot [3];
  logic [pvca_pkg::MEAN_BITS-1:0]    quot_next [3];
  logic [COUNT_BITS-1:0]             div_cnt;
  logic [pvca_pkg::STEP_BITS-1:0]    bit_idx;
  logic [SW-1:0]                     shifted;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q   <= request;
      slot_ok <= 32'(request.vertex_index) < 32'(SLOT_DEPTH);
    end
  end

  assign rd_addr = AW'(req_q.vertex_index);
  assign samp[0] = req_q.red_sample;
  assign samp[1] = req_q.green_sample;
  assign samp[2] = req_q.blue_sample;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  assign word = slot_ok ? rd_q : '0;
  assign cnt  = word[3*SW +: COUNT_BITS];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_addr;
    mem_wdata = '0;
    if (cmd.clear_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
    end else if (cmd.exec && slot_ok) begin
      if (req_q.operation == pvca_pkg::OP_ACC && cnt != CountMax) begin
        mem_we = 1'b1;
        for (int k = 0; k < 3; k++) begin
          mem_wdata[k*SW +: SW] = word[k*SW +: SW] + SW'(samp[k]);
        end
        mem_wdata[3*SW +: COUNT_BITS] = cnt + COUNT_BITS'(1);
      end else if (req_q.operation == pvca_pkg::OP_READ_CLR) begin
        mem_we = 1'b1;
      end
    end
  end

  // restoring division, one quotient bit per step, quotient known to fit 8 bits
  assign shifted = SW'(div_cnt) << bit_idx;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rem_next[k]  = rem[k];
      quot_next[k] = quot[k];
      if (rem[k] >= shifted) begin
        rem_next[k]           = rem[k] - shifted;
        quot_next[k][bit_idx] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int k = 0; k < 3; k++) begin
        rem[k]  <= word[k*SW +: SW];
        quot[k] <= '0;
      end
      div_cnt <= cnt;
      bit_idx <= pvca_pkg::STEP_BITS'(pvca_pkg::QUOT_STEPS - 1);
    end else if (cmd.div_step) begin
      for (int k = 0; k < 3; k++) begin
        rem[k]  <= rem_next[k];
        quot[k] <= quot_next[k];
      end
      bit_idx <= bit_idx - pvca_pkg::STEP_BITS'(1);
    end
  end

  assign status.is_read    = (req_q.operation == pvca_pkg::OP_READ) ||
                             (req_q.operation == pvca_pkg::OP_READ_CLR);
  assign status.div_last   = (bit_idx == '0);
  assign status.clear_last = (clr_addr == LastAddr);

  always_ff @(posedge clk) begin
    if (cmd.div_step && status.div_last) begin
      result.slot_index   <= req_q.vertex_index;
      result.mean_red     <= (div_cnt == '0) ? '0 : quot_next[0];
      result.mean_green   <= (div_cnt == '0) ? '0 : quot_next[1];
      result.mean_blue    <= (div_cnt == '0) ? '0 : quot_next[2];
      result.sample_count <= 16'(div_cnt);
      result.no_samples   <= (div_cnt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.div_step && status.div_last;
    end
  end

  `PVCA_ASSERT_SAME(a_done_after_div, clk, rst, done, $past(cmd.div_step), "result without division")
  `PVCA_ASSERT_SAME(a_no_write_in_div, clk, rst, cmd.div_step, !mem_we, "memory written while dividing")
  `PVCA_ASSERT_SAME(a_empty_zero, clk, rst, done && result.no_samples, (result.mean_red == '0) && (result.mean_green == '0) && (result.mean_blue == '0), "empty slot with nonzero mean")

endmodule

// ----- hdl/per_vertex_color_averager_core.sv -----
// Top level: per-vertex RGB mean accumulator with command-style request port.
// Accumulate and no-op requests pass through a fetch state (slot memory read) and an exec state (write back).
// Read requests also run the 8-step radix-2 divider after the exec state.
// The result strobe (done) is high for one cycle as busy falls; results cannot be held off.
// After reset the slot memory is cleared one entry a cycle, with busy high throughout.
`timescale 1ns / 1ps
module per_vertex_color_averager_core #(
  parameter int SLOT_DEPTH = 4096,
  parameter int COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  pvca_pkg::request_t request,
  output pvca_pkg::result_t  result,
  output logic               done
);

  pvca_pkg::cmd_t    cmd;
  pvca_pkg::status_t status;

  pvca_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  pvca_datapath #(
    .SLOT_DEPTH (SLOT_DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .status  (status),
    .result  (result),
    .done    (done)
  );

endmodule

// ----- test/tb_top.sv -----
// Testbench for per_vertex_color_averager_core: request driver, result monitor, predictor.
`timescale 1ns / 1ps
module tb_top;

  localparam int          NUM_SLOTS     = 4096;
  localparam logic [15:0] COUNT_FULL    = 16'hFFFF;
  localparam int          RANDOM_PHASE  = 233;
  localparam int          DRAIN_CYCLES  = 30;
  localparam longint      CYCLE_LIMIT   = 2000000;

  typedef struct {
    pvca_pkg::request_t req;
    int unsigned        idle_pct;
  } pending_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  pvca_pkg::request_t request = '0;
  pvca_pkg::result_t  result;
  logic               done;

  pending_t          pending_q[$];
  pvca_pkg::result_t expected_means[$];
  int unsigned       queued_count = 0;
  int unsigned       accepted_count = 0;
  int unsigned       fail_count = 0;
  longint            cycle_count = 0;

  logic [23:0] sum_red   [NUM_SLOTS];
  logic [23:0] sum_green [NUM_SLOTS];
  logic [23:0] sum_blue  [NUM_SLOTS];
  logic [15:0] count_tally [NUM_SLOTS];

  per_vertex_color_averager_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .result (result),
    .done   (done)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] mean_of_sum(input logic [23:0] s, input logic [15:0] n);
    logic [23:0] q;
    q = s / {8'd0, n};
    return q[7:0];
  endfunction

  task automatic apply_request(input pvca_pkg::request_t req);
    pvca_pkg::result_t res;
    logic [15:0]       n;
    logic [11:0]       idx;
    idx = req.vertex_index;
    n   = count_tally[idx];
    unique case (req.operation)
      pvca_pkg::OP_ACC: begin
        if (n != COUNT_FULL) begin
          sum_red[idx]     = sum_red[idx] + 24'(req.red_sample);
          sum_green[idx]   = sum_green[idx] + 24'(req.green_sample);
          sum_blue[idx]    = sum_blue[idx] + 24'(req.blue_sample);
          count_tally[idx] = n + 16'd1;
        end
      end
      pvca_pkg::OP_READ, pvca_pkg::OP_READ_CLR: begin
        res.slot_index   = idx;
        res.sample_count = n;
        res.no_samples   = (n == 16'd0);
        if (n == 16'd0) begin
          res.mean_red   = '0;
          res.mean_green = '0;
          res.mean_blue  = '0;
        end else begin
          res.mean_red   = mean_of_sum(sum_red[idx], n);
          res.mean_green = mean_of_sum(sum_green[idx], n);
          res.mean_blue  = mean_of_sum(sum_blue[idx], n);
        end
        expected_means.push_back(res);
        if (req.operation == pvca_pkg::OP_READ_CLR) begin
          sum_red[idx]     = '0;
          sum_green[idx]   = '0;
          sum_blue[idx]    = '0;
          count_tally[idx] = '0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic push_req(input logic [1:0] op, input logic [11:0] idx, input logic [7:0] r,
                          input logic [7:0] g, input logic [7:0] b, input int unsigned pct);
    pending_t p;
    p.req.operation    = op;
    p.req.vertex_index = idx;
    p.req.red_sample   = r;
    p.req.green_sample = g;
    p.req.blue_sample  = b;
    p.idle_pct         = pct;
    pending_q.push_back(p);
    queued_count++;
  endtask

  task automatic check_field(input string fname, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", fname, want, got);
      fail_count++;
    end
  endtask

  // request driver
  always @(posedge clk) begin : drive_proc
    logic     take;
    pending_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      take = start && !busy;
      if (take) begin
        apply_request(request);
        accepted_count++;
      end
      if (!start || take) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= pending_q[0].idle_pct) begin
          nxt = pending_q.pop_front();
          start   <= 1'b1;
          request <= nxt.req;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : monitor_proc
    pvca_pkg::result_t want;
    if (!rst && done) begin
      if (expected_means.size() == 0) begin
        $error("unexpected result for slot %0d", result.slot_index);
        fail_count++;
      end else begin
        want = expected_means.pop_front();
        check_field("slot_index", 32'(want.slot_index), 32'(result.slot_index));
        check_field("mean_red", 32'(want.mean_red), 32'(result.mean_red));
        check_field("mean_green", 32'(want.mean_green), 32'(result.mean_green));
        check_field("mean_blue", 32'(want.mean_blue), 32'(result.mean_blue));
        check_field("sample_count", 32'(want.sample_count), 32'(result.sample_count));
        check_field("no_samples", 32'(want.no_samples), 32'(result.no_samples));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL per_vertex_color_averager_core");
      $finish;
    end
  end

  initial begin : stim_proc
    int unsigned phase_pct [4];
    logic [11:0] hot_slots [8];
    logic [1:0]  op;
    logic [11:0] idx;
    int unsigned roll;

    sum_red     = '{default: '0};
    sum_green   = '{default: '0};
    sum_blue    = '{default: '0};
    count_tally = '{default: '0};

    // directed: empty reads, extremes, truncation, clear, no-op
    push_req(pvca_pkg::OP_READ,     12'd0,    8'd0,   8'd0,   8'd0,   0);
    push_req(pvca_pkg::OP_READ_CLR, 12'hFFF,  8'hFF,  8'hFF,  8'hFF,  0);
    push_req(pvca_pkg::OP_ACC,      12'd0,    8'hFF,  8'hFF,  8'hFF,  0);
    push_req(pvca_pkg::OP_ACC,      12'd0,    8'h00,  8'h00,  8'h00,  0);
    push_req(pvca_pkg::OP_ACC,      12'd0,    8'd1,   8'd2,   8'd3,   0);
    push_req(pvca_pkg::OP_READ,     12'd0,    8'd0,   8'd0,   8'd0,   0);
    push_req(pvca_pkg::OP_ACC,      12'hFFF,  8'hFF,  8'h00,  8'hAA,  0);
    push_req(pvca_pkg::OP_ACC,      12'hFFF,  8'h55,  8'hFF,  8'h00,  0);
    push_req(pvca_pkg::OP_READ_CLR, 12'hFFF,  8'd0,   8'd0,   8'd0,   0);
    push_req(pvca_pkg::OP_READ,     12'hFFF,  8'd0,   8'd0,   8'd0,   0);
    push_req(pvca_pkg::OP_NOP,      12'd0,    8'hFF,  8'hFF,  8'hFF,  0);
    push_req(pvca_pkg::OP_READ,     12'd0,    8'd0,   8'd0,   8'd0,   0);
    push_req(pvca_pkg::OP_ACC,      12'hAAA,  8'hAA,  8'hAA,  8'hAA,  0);
    push_req(pvca_pkg::OP_ACC,      12'h555,  8'h55,  8'h55,  8'h55,  0);
    push_req(pvca_pkg::OP_READ,     12'hAAA,  8'd0,   8'd0,   8'd0,   0);
    push_req(pvca_pkg::OP_READ_CLR, 12'h555,  8'd0,   8'd0,   8'd0,   0);
    push_req(pvca_pkg::OP_READ_CLR, 12'd0,    8'd0,   8'd0,   8'd0,   0);
    push_req(pvca_pkg::OP_READ,     12'd0,    8'd0,   8'd0,   8'd0,   0);

    // random traffic on a few busy slots with occasional scattered addresses
    phase_pct = '{0, 51, 0, 34};
    hot_slots[0] = 12'd0;
    hot_slots[1] = 12'hFFF;
    for (int i = 2; i < 8; i++) hot_slots[3'(i)] = 12'($urandom_range(4095));
    for (int p = 0; p < 4; p++) begin
      for (int i = 0; i < RANDOM_PHASE; i++) begin
        roll = $urandom_range(99);
        if (roll < 68)      op = pvca_pkg::OP_ACC;
        else if (roll < 81) op = pvca_pkg::OP_READ;
        else if (roll < 94) op = pvca_pkg::OP_READ_CLR;
        else                op = pvca_pkg::OP_NOP;
        if ($urandom_range(9) == 0) idx = 12'($urandom_range(4095));
        else                        idx = hot_slots[3'($urandom_range(7))];
        push_req(op, idx, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), phase_pct[2'(p)]);
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count != queued_count || expected_means.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("PASS per_vertex_color_averager_core");
    else
      $display("FAIL per_vertex_color_averager_core");
    $finish;
  end

endmodule
